// ===== hw/rtl/gbcw_pkg.sv =====
// package with shared types and constants of the grid walk block
`timescale 1ns / 1ps
package gbcw_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int RowW = $clog2(MaxRows);
    localparam int ColW = $clog2(MaxCols);
    localparam int AddrW = RowW + ColW;
    localparam int Cells = MaxRows * MaxCols;
    localparam int DistW = AddrW + 1;
    localparam logic [DistW-1:0] Unreached = '1;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_MOVE = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] KIND_FREE = 2'd0;
    localparam logic [1:0] KIND_WALL = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] DIR_DOWN = 2'd0;
    localparam logic [1:0] DIR_LEFT = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_UP = 2'd3;

    localparam logic [1:0] STATUS_MOVE = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_WALK = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic [1:0] cell_kind;
    } in_item_t;

    typedef struct packed {
        logic [1:0] move_dir;
        logic [1:0] walk_status;
        logic       final_move;
    } out_item_t;

    // neighbor probe request and answer between sequencer and unit
    typedef struct packed {
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        logic [1:0]      dir;
        logic [6:0]      rows;
        logic [6:0]      cols;
    } probe_req_t;

    typedef struct packed {
        logic            ok;
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
    } probe_rsp_t;
endpackage

// ===== hw/rtl/gbcw_step.sv =====
// shared neighbor step unit: one direction offset and bounds test
`timescale 1ns / 1ps
module gbcw_step (
    input  gbcw_pkg::probe_req_t req,
    output gbcw_pkg::probe_rsp_t rsp
);
    import gbcw_pkg::*;
    logic [RowW:0] nr;
    logic [ColW:0] nc;
    logic [7:0] rlim;
    logic [7:0] clim;
    always_comb begin
        nr = {1'b0, req.row};
        nc = {1'b0, req.col};
        case (req.dir)
            DIR_DOWN: nr = nr + 1'b1;
            DIR_LEFT: nc = nc - 1'b1;
            DIR_RIGHT: nc = nc + 1'b1;
            default: nr = nr - 1'b1;
        endcase
        rlim = (req.rows > 7'(MaxRows)) ? 8'(MaxRows) : {1'b0, req.rows};
        clim = (req.cols > 7'(MaxCols)) ? 8'(MaxCols) : {1'b0, req.cols};
        rsp.ok = !((req.dir == DIR_UP) && (req.row == '0))
              && !((req.dir == DIR_LEFT) && (req.col == '0))
              && (8'(nr) < rlim) && (8'(nc) < clim);
        rsp.row = nr[RowW-1:0];
        rsp.col = nc[ColW-1:0];
    end
endmodule

// ===== hw/rtl/grid_bfs_closed_walk.sv =====
// top level: cell store, distance store, search queue and walk sequencer
`timescale 1ns / 1ps
// One item at a time. A search first clears the 4096-entry distance store
// one entry a cycle, then pops each queued cell (pop, head and distance
// states) and probes its neighbors in turn: an in-bounds one through the
// probe, read and test states, an out-of-bounds one through probe alone,
// all via the one step unit and the memories. A move request probes up to
// four neighbors through the move probe, read and test states.
module grid_bfs_closed_walk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gbcw_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gbcw_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data
);
    import gbcw_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_POP = 4'd2;
    localparam logic [3:0] ST_HEAD = 4'd3;
    localparam logic [3:0] ST_PROBE = 4'd4;
    localparam logic [3:0] ST_READ = 4'd5;
    localparam logic [3:0] ST_TEST = 4'd6;
    localparam logic [3:0] ST_MPROBE = 4'd7;
    localparam logic [3:0] ST_MREAD = 4'd8;
    localparam logic [3:0] ST_MTEST = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;
    localparam logic [3:0] ST_DIST = 4'd11;

    logic [1:0]       cells_mem [Cells];
    logic [DistW-1:0] dist_mem  [Cells];
    logic [AddrW-1:0] queue_mem [Cells];

    logic [3:0]       state_reg, state_next;
    logic [6:0]       rows_reg, cols_reg;
    logic [19:0]      walk_len_reg, moves_reg;
    logic [AddrW-1:0] start_reg, pos_reg, cur_reg, nb_reg, addr_reg;
    logic [AddrW:0]   head_reg, tail_reg;
    logic [DistW-1:0] cur_dist_reg;
    logic [1:0]       dir_reg;
    logic             failed_reg;
    logic [1:0]       kind_rd;
    logic [DistW-1:0] dist_rd;
    logic [AddrW-1:0] queue_rd;
    out_item_t        out_reg;
    probe_req_t       preq;
    probe_rsp_t       prsp;
    logic             is_ok;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data = out_reg;

    always_comb begin
        preq.row = (state_reg == ST_PROBE) ? cur_reg[AddrW-1:ColW] : pos_reg[AddrW-1:ColW];
        preq.col = (state_reg == ST_PROBE) ? cur_reg[ColW-1:0] : pos_reg[ColW-1:0];
        preq.dir = dir_reg;
        preq.rows = rows_reg;
        preq.cols = cols_reg;
    end

    gbcw_step u_step (.req(preq), .rsp(prsp));

    // memories: registered reads, cell and distance at addr_reg, queue at head_reg
    always_ff @(posedge aclk) begin
        kind_rd <= cells_mem[addr_reg];
        dist_rd <= dist_mem[addr_reg];
        queue_rd <= queue_mem[head_reg[AddrW-1:0]];
        if (state_reg == ST_IDLE && s_valid && s_ready && s_data.func == FUNC_WRITE
            && s_data.cell_kind != KIND_NONE)
            cells_mem[{s_data.cell_row, s_data.cell_col}] <= s_data.cell_kind;
        if (state_reg == ST_CLEAR)
            dist_mem[addr_reg] <= (addr_reg == start_reg) ? '0 : Unreached;
        else if (state_reg == ST_TEST && is_ok)
            dist_mem[nb_reg] <= cur_dist_reg + 1'b1;
        if (state_reg == ST_CLEAR && addr_reg == '0)
            queue_mem[0] <= start_reg;
        else if (state_reg == ST_TEST && is_ok)
            queue_mem[tail_reg[AddrW-1:0]] <= nb_reg;
    end

    assign is_ok = (kind_rd == KIND_FREE) && (dist_rd == Unreached);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_data.func == FUNC_SEARCH) state_next = ST_CLEAR;
                    else if (s_data.func == FUNC_MOVE) begin
                        if (failed_reg || moves_reg == '0) state_next = ST_OUT;
                        else state_next = ST_MPROBE;
                    end
                end
            end
            ST_CLEAR: if (addr_reg == AddrW'(Cells - 1)) state_next = ST_POP;
            ST_POP: state_next = (head_reg < tail_reg) ? ST_HEAD : ST_IDLE;
            ST_HEAD: state_next = ST_DIST;
            ST_DIST: state_next = ST_PROBE;
            ST_PROBE: state_next = prsp.ok ? ST_READ : ((dir_reg == DIR_UP) ? ST_POP : ST_PROBE);
            ST_READ: state_next = ST_TEST;
            ST_TEST: state_next = (dir_reg == DIR_UP) ? ST_POP : ST_PROBE;
            ST_MPROBE: state_next = prsp.ok ? ST_MREAD
                                            : ((dir_reg == DIR_UP) ? ST_OUT : ST_MPROBE);
            ST_MREAD: state_next = ST_MTEST;
            ST_MTEST: begin
                if (kind_rd != KIND_WALL && dist_rd != Unreached
                    && 20'(dist_rd) <= moves_reg - 1'b1) state_next = ST_OUT;
                else if (dir_reg == DIR_UP) state_next = ST_OUT;
                else state_next = ST_MPROBE;
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
            walk_len_reg <= '0;
            moves_reg <= '0;
            start_reg <= '0;
            pos_reg <= '0;
            failed_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            dir_reg <= '0;
            addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ROWS) rows_reg <= cfg_data[6:0];
                else if (cfg_index == REG_COLS) cols_reg <= cfg_data[6:0];
                else if (cfg_index == REG_WALK) walk_len_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    dir_reg <= '0;
                    addr_reg <= '0;
                    if (s_valid && s_ready && s_data.func == FUNC_MOVE && failed_reg)
                        out_reg <= '{move_dir: '0, walk_status: STATUS_FAIL, final_move: 1'b0};
                    else if (s_valid && s_ready && s_data.func == FUNC_MOVE
                             && moves_reg == '0)
                        out_reg <= '{move_dir: '0, walk_status: STATUS_DONE, final_move: 1'b0};
                    else
                        out_reg <= '0;
                    if (s_valid && s_ready) begin
                        if (s_data.func == FUNC_WRITE && s_data.cell_kind == KIND_START)
                            start_reg <= {s_data.cell_row, s_data.cell_col};
                        if (s_data.func == FUNC_SEARCH) begin
                            head_reg <= '0;
                            tail_reg <= (AddrW + 1)'(1);
                        end
                    end
                end
                ST_CLEAR: addr_reg <= addr_reg + 1'b1;
                ST_POP: begin
                    dir_reg <= '0;
                    if (head_reg >= tail_reg) begin
                        pos_reg <= start_reg;
                        moves_reg <= walk_len_reg;
                        failed_reg <= walk_len_reg[0];
                    end
                end
                ST_HEAD: begin
                    cur_reg <= queue_rd;
                    addr_reg <= queue_rd;
                    head_reg <= head_reg + 1'b1;
                end
                ST_DIST: ;
                ST_PROBE: begin
                    if (dir_reg == '0) cur_dist_reg <= dist_rd;
                    nb_reg <= {prsp.row, prsp.col};
                    addr_reg <= {prsp.row, prsp.col};
                    if (!prsp.ok) dir_reg <= dir_reg + 1'b1;
                end
                ST_READ: ;
                ST_TEST: begin
                    if (is_ok) tail_reg <= tail_reg + 1'b1;
                    dir_reg <= dir_reg + 1'b1;
                end
                ST_MPROBE: begin
                    nb_reg <= {prsp.row, prsp.col};
                    addr_reg <= {prsp.row, prsp.col};
                    if (!prsp.ok) begin
                        dir_reg <= dir_reg + 1'b1;
                        if (dir_reg == DIR_UP) begin
                            failed_reg <= 1'b1;
                            out_reg.walk_status <= STATUS_FAIL;
                        end
                    end
                end
                ST_MREAD: ;
                ST_MTEST: begin
                    if (kind_rd != KIND_WALL && dist_rd != Unreached
                        && 20'(dist_rd) <= moves_reg - 1'b1) begin
                        pos_reg <= nb_reg;
                        moves_reg <= moves_reg - 1'b1;
                        out_reg <= '{move_dir: dir_reg, walk_status: STATUS_MOVE,
                                     final_move: (moves_reg == 20'd1)};
                    end else begin
                        dir_reg <= dir_reg + 1'b1;
                        if (dir_reg == DIR_UP) begin
                            failed_reg <= 1'b1;
                            out_reg.walk_status <= STATUS_FAIL;
                        end
                    end
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // cur_dist is the distance of the popped cell: read at its address in ST_DIST
    a_out_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");
    a_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HEAD) |-> (head_reg < tail_reg)) else $error("queue underrun");
endmodule

// ===== sim/testbench.sv =====
// testbench for grid_bfs_closed_walk: a self-checking predictor with random grids and walks
`timescale 1ns / 1ps
module testbench;
    import gbcw_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_ROWS;
    logic [19:0] cfg_data = '0;

    grid_bfs_closed_walk dut (.*);

    always #6 aclk = ~aclk;

    in_item_t  pending_items[$];
    out_item_t expected_moves[$];
    int        error_count = 0;
    int        idle_mode = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;

    // predictor state
    logic [1:0] kind_mem[Cells];
    int         dist_mem[Cells];
    int         bfs_fifo[Cells];
    int         start_r = 0, start_c = 0, walk_r = 0, walk_c = 0;
    int         moves_left = 0;
    bit         walk_failed = 0;
    int         rows_cfg = 64, cols_cfg = 64, walk_cfg = 0;
    bit         written[Cells];

    const int step_r[4] = '{1, 0, 0, -1};
    const int step_c[4] = '{0, -1, 1, 0};

    function automatic bit on_grid(int r, int c);
        int rr, cc;
        rr = rows_cfg > MaxRows ? MaxRows : rows_cfg;
        cc = cols_cfg > MaxCols ? MaxCols : cols_cfg;
        return r >= 0 && c >= 0 && r < rr && c < cc;
    endfunction

    function automatic void run_search();
        int head, tail, cur, nr, nc, n;
        head = 0;
        tail = 0;
        foreach (dist_mem[i]) dist_mem[i] = -1;
        dist_mem[start_r * MaxCols + start_c] = 0;
        bfs_fifo[tail++] = start_r * MaxCols + start_c;
        while (head < tail) begin
            cur = bfs_fifo[head++];
            for (int d = 0; d < 4; d++) begin
                nr = cur / MaxCols + step_r[d];
                nc = cur % MaxCols + step_c[d];
                if (on_grid(nr, nc)) begin
                    n = nr * MaxCols + nc;
                    if (kind_mem[n] == KIND_FREE && dist_mem[n] == -1 && tail < Cells) begin
                        dist_mem[n] = dist_mem[cur] + 1;
                        bfs_fifo[tail++] = n;
                    end
                end
            end
        end
        walk_r = start_r;
        walk_c = start_c;
        moves_left = walk_cfg;
        walk_failed = walk_cfg[0];
    endfunction

    function automatic void predict_item(in_item_t it);
        out_item_t res;
        int nr, nc, n;
        res = '0;
        if (it.func == FUNC_WRITE) begin
            if (it.cell_kind != KIND_NONE) begin
                kind_mem[it.cell_row * MaxCols + it.cell_col] = it.cell_kind;
                if (it.cell_kind == KIND_START) begin
                    start_r = int'(it.cell_row);
                    start_c = int'(it.cell_col);
                end
            end
        end else if (it.func == FUNC_SEARCH) begin
            run_search();
        end else if (it.func == FUNC_MOVE) begin
            if (walk_failed) begin
                res.walk_status = STATUS_FAIL;
            end else if (moves_left == 0) begin
                res.walk_status = STATUS_DONE;
            end else begin
                res.walk_status = STATUS_FAIL;
                for (int d = 0; d < 4; d++) begin
                    nr = walk_r + step_r[d];
                    nc = walk_c + step_c[d];
                    n = nr * MaxCols + nc;
                    if (res.walk_status == STATUS_FAIL && on_grid(nr, nc)
                        && kind_mem[n] != KIND_WALL && dist_mem[n] != -1
                        && dist_mem[n] <= moves_left - 1) begin
                        walk_r = nr;
                        walk_c = nc;
                        moves_left--;
                        res.move_dir = d[1:0];
                        res.walk_status = STATUS_MOVE;
                        res.final_move = moves_left == 0;
                    end
                end
                if (res.walk_status == STATUS_FAIL) walk_failed = 1;
            end
            expected_moves.push_back(res);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_item(s_data);
            if (pending_items.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 11) &&
                !(idle_mode == 1 && $urandom_range(99) < 80)) begin
                s_valid <= 1;
                s_data <= pending_items.pop_front();
            end else begin
                s_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_moves.size() == 0) begin
                report_mismatch("unexpected transaction", int'(m_data), 0);
            end else begin
                want = expected_moves.pop_front();
                if (m_data.move_dir != want.move_dir)
                    report_mismatch("move_dir", m_data.move_dir, want.move_dir);
                if (m_data.walk_status != want.walk_status)
                    report_mismatch("walk_status", m_data.walk_status, want.walk_status);
                if (m_data.final_move != want.final_move)
                    report_mismatch("final_move", m_data.final_move, want.final_move);
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left <= 400;
            m_ready <= 0;
        end else begin
            m_ready <= !(idle_mode == 0 && $urandom_range(99) < 80) &&
                       !(idle_mode == 1 && $urandom_range(99) < 11);
        end
    end

    task automatic push_item(logic [1:0] f, int r, int c, logic [1:0] k);
        in_item_t it;
        it.func = f;
        it.cell_row = r[5:0];
        it.cell_col = c[5:0];
        it.cell_kind = k;
        pending_items.push_back(it);
        if (f == FUNC_WRITE && k != KIND_NONE) written[r * MaxCols + c] = 1;
    endtask

    task automatic settle();
        while (pending_items.size() > 0 || s_valid || expected_moves.size() > 0 || !s_ready)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, int value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value[19:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_ROWS: rows_cfg = value & 8'h7f;
            REG_COLS: cols_cfg = value & 8'h7f;
            default:  walk_cfg = value & 20'hfffff;
        endcase
        @(posedge aclk);
    endtask

    // write the cells in use, mostly free with some walls; some already written cells are skipped
    task automatic fill_grid(int rows, int cols, int wall_pct);
        int rr, cc, p;
        rr = rows > MaxRows ? MaxRows : rows;
        cc = cols > MaxCols ? MaxCols : cols;
        for (int r = 0; r < rr; r++) begin
            for (int c = 0; c < cc; c++) begin
                p = $urandom_range(99);
                if (p < 3) push_item(FUNC_WRITE, r, c, KIND_NONE);
                if (p < wall_pct) push_item(FUNC_WRITE, r, c, KIND_WALL);
                else if (p < 97 || !written[r * MaxCols + c])
                    push_item(FUNC_WRITE, r, c, KIND_FREE);
            end
        end
    endtask

    task automatic run_phase(int rows, int cols, int walk, int moves);
        int rr, cc;
        settle();
        set_reg(REG_ROWS, rows | ($urandom_range(8191) << 7));
        set_reg(REG_COLS, cols);
        set_reg(REG_WALK, walk);
        fill_grid(rows, cols, $urandom_range(25));
        rr = rows > MaxRows ? MaxRows : rows;
        cc = cols > MaxCols ? MaxCols : cols;
        if ($urandom_range(9) == 0 || rr == 0 || cc == 0)
            push_item(FUNC_WRITE, $urandom_range(63), $urandom_range(63), KIND_START);
        if (rr > 0 && cc > 0)
            push_item(FUNC_WRITE, $urandom_range(rr - 1), $urandom_range(cc - 1), KIND_START);
        if ($urandom_range(9) == 0) push_item(FUNC_NONE, $urandom_range(63), $urandom_range(63),
                                              2'($urandom_range(3)));
        push_item(FUNC_SEARCH, $urandom_range(63), $urandom_range(63), 2'($urandom_range(3)));
        for (int i = 0; i < moves; i++)
            push_item(FUNC_MOVE, $urandom_range(63), $urandom_range(63), 2'($urandom_range(3)));
    endtask

    initial begin
        int total, rows, cols, walk;
        foreach (kind_mem[i]) kind_mem[i] = KIND_FREE;
        foreach (dist_mem[i]) dist_mem[i] = -1;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        // directed: move before any walk, unknown func, ignored kind
        push_item(FUNC_MOVE, 0, 0, KIND_FREE);
        push_item(FUNC_NONE, 63, 63, KIND_NONE);
        push_item(FUNC_WRITE, 0, 0, KIND_NONE);
        settle();
        set_reg(REG_ROWS, 2);
        set_reg(REG_COLS, 3);
        set_reg(REG_WALK, 4);
        for (int c = 0; c < 3; c++) push_item(FUNC_WRITE, 0, c, KIND_FREE);
        push_item(FUNC_WRITE, 1, 0, KIND_FREE);
        push_item(FUNC_WRITE, 1, 1, KIND_WALL);
        push_item(FUNC_WRITE, 1, 2, KIND_START);
        push_item(FUNC_WRITE, 0, 0, KIND_START);
        push_item(FUNC_SEARCH, 0, 0, KIND_FREE);
        for (int i = 0; i < 6; i++) push_item(FUNC_MOVE, 0, 0, KIND_FREE);
        settle();
        set_reg(REG_WALK, 3);
        push_item(FUNC_SEARCH, 0, 0, KIND_FREE);
        push_item(FUNC_MOVE, 0, 0, KIND_FREE);
        push_item(FUNC_MOVE, 0, 0, KIND_FREE);
        settle();
        set_reg(REG_ROWS, 0);
        set_reg(REG_WALK, 2);
        push_item(FUNC_SEARCH, 0, 0, KIND_FREE);
        push_item(FUNC_MOVE, 0, 0, KIND_FREE);
        // extremes of the grid and walk length
        run_phase(1, 64, 62, 64);
        run_phase(64, 1, 20, 22);
        run_phase(1, 1, 2, 3);
        run_phase(4, 4, 1048574, 20);
        run_phase(4, 4, 1048575, 3);
        total = 0;
        while (total < 900) begin
            idle_mode = total < 300 ? 0 : (total < 600 ? 1 : 2);
            rows = $urandom_range(1, 8);
            cols = $urandom_range(1, 8);
            walk = $urandom_range(9) == 0 ? $urandom_range(1, 31) : 2 * $urandom_range(20);
            run_phase(rows, cols, walk, walk + $urandom_range(3));
            if (total < 100) hold_requests++;
            total += rows * cols + walk + 4;
        end
        // saturated sizes
        run_phase(127, 2, 40, 42);
        run_phase(2, 100, 60, 62);
        settle();
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #(300_000_000);
        $display("testbench: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/gbcw_pkg.sv
hw/rtl/gbcw_step.sv
hw/rtl/grid_bfs_closed_walk.sv
sim/testbench.sv
